FILE: hdl/conv3_pkg.sv
// Shared types and constants for the 3x3 replicate-border convolution block.
`timescale 1ns / 1ps

package conv3_pkg;

    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int ECOEF_W    = COEF_W + 2;
    localparam int PROD_W     = PIX_W + ECOEF_W;
    localparam int CSUM_W     = PROD_W + 2;
    localparam int SUM_W      = CSUM_W + 2;
    localparam int OUT_W      = 35;
    localparam int OUT_BUS_W  = 40;
    localparam int TAPS       = 3;
    localparam int ROW_W      = 16;
    localparam int IWIDTH_W   = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int OQ_DEPTH   = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_TOP     = 3'd2,
        REG_COEF_MID     = 3'd3,
        REG_COEF_BOTTOM  = 3'd4
    } cfg_reg_t;

    typedef logic signed [PIX_W-1:0]   pix_t;
    typedef logic signed [ECOEF_W-1:0] ecoef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CSUM_W-1:0]  csum_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [ROW_W-1:0]          row_t;

    // One window column: samples of the row above, the current row and the row below.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    // Merged coefficients applied to one window column.
    typedef struct packed {
        ecoef_t top;
        ecoef_t mid;
        ecoef_t bot;
    } ecoef_col_t;

    typedef struct packed {
        logic                     done;
        logic signed [OUT_W-1:0]  value;
    } oq_word_t;

endpackage

FILE: hdl/conv3_cell.sv
// One window column cell: holds a column, shifts it on, and forms its three products.
`timescale 1ns / 1ps

module conv3_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  conv3_pkg::col_t        col_in,
    input  conv3_pkg::ecoef_col_t  coef,
    output conv3_pkg::col_t        col_out,
    output conv3_pkg::csum_t       sum_out
);

    conv3_pkg::col_t  col_reg, col_next;
    conv3_pkg::prod_t prod_top_reg, prod_mid_reg, prod_bot_reg;
    conv3_pkg::csum_t sum_reg;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    // Registered products of the settled column, then the registered column sum.
    always_ff @(posedge aclk) begin
        prod_top_reg <= conv3_pkg::prod_t'(col_reg.top) * conv3_pkg::prod_t'(coef.top);
        prod_mid_reg <= conv3_pkg::prod_t'(col_reg.mid) * conv3_pkg::prod_t'(coef.mid);
        prod_bot_reg <= conv3_pkg::prod_t'(col_reg.bot) * conv3_pkg::prod_t'(coef.bot);
        sum_reg      <= conv3_pkg::csum_t'(prod_top_reg) + conv3_pkg::csum_t'(prod_mid_reg)
                        + conv3_pkg::csum_t'(prod_bot_reg);
    end

    assign col_out = col_reg;
    assign sum_out = sum_reg;

endmodule

FILE: hdl/conv3_oq.sv
// Result queue between the arithmetic pipeline and the master port.
`timescale 1ns / 1ps

module conv3_oq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  conv3_pkg::oq_word_t   push_word,
    output logic                  word_valid,
    input  logic                  pop,
    output conv3_pkg::oq_word_t   head_word
);

    localparam int PW = $clog2(conv3_pkg::OQ_DEPTH);
    localparam int NW = $clog2(conv3_pkg::OQ_DEPTH + 1);

    conv3_pkg::oq_word_t slot_reg [conv3_pkg::OQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_pop;

    assign word_valid = (count_reg != '0);
    assign do_pop     = pop && word_valid;
    assign head_word  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        case ({push, do_pop})
            2'b10:   count_next = count_reg + NW'(1);
            2'b01:   count_next = count_reg - NW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hdl/conv3x3_replicate_border.sv
// Top level: 3x3 convolution with replicated borders over a raster pixel stream.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one word per pixel in raster order, s_tdata = signed sample,
//   s_tuser[0] = 1 marks a drain word. After the last pixel of a frame send
//   image_width + 1 more words (any content); they flush the last row of
//   results. A drain word outside that flush is dropped with no result.
//   m_ channel: one word per pixel, raster order; m_tdata[34:0] is the exact
//   signed sum, m_tlast marks the result for the last pixel of the frame.
//   Results lag the inputs by one row and one pixel.
//   cfg channel: cfg_index selects width, height, or a coefficient row; a size
//   write restarts the frame. Write only while no word is in flight.
//   Each result passes stage 1, the window, product and sum registers and the result queue.
//   Throughput: one word per cycle, set by the three-column cell chain and the
//   one-read/one-write line stores. An 8-word result queue absorbs stalls;
//   s_tready drops only while 8 results are outstanding.
//   Reset: counters and window clear, registers take their defaults; the line
//   stores are not cleared, since unwritten entries never reach a result.
module conv3x3_replicate_border #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [conv3_pkg::PIX_W-1:0]           s_tdata,   // [15:0] pixel_value
    input  logic [0:0]                            s_tuser,   // [0] action
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [conv3_pkg::OUT_BUS_W-1:0]       m_tdata,   // [34:0] filtered_value, [39:35] zero
    output logic                                  m_tlast,   // frame_done
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW        = $clog2(MAX_WIDTH + 1);
    localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int CRW       = $clog2(conv3_pkg::OQ_DEPTH + 1);

    function automatic conv3_pkg::ecoef_t merge_coef(
        input logic [conv3_pkg::CFG_DATA_W-1:0] row,
        input logic [1:0] lsel,
        input logic [1:0] csel,
        input logic [1:0] rsel,
        input logic [1:0] idx
    );
        conv3_pkg::ecoef_t acc;
        acc = '0;
        if (lsel == idx) begin
            acc = acc + conv3_pkg::ecoef_t'(signed'(row[conv3_pkg::COEF_W-1:0]));
        end
        if (csel == idx) begin
            acc = acc + conv3_pkg::ecoef_t'(signed'(row[2*conv3_pkg::COEF_W-1:conv3_pkg::COEF_W]));
        end
        if (rsel == idx) begin
            acc = acc + conv3_pkg::ecoef_t'(signed'(row[3*conv3_pkg::COEF_W-1:2*conv3_pkg::COEF_W]));
        end
        return acc;
    endfunction

    // configuration
    logic [CW-1:0]                    width_reg, width_next;
    conv3_pkg::row_t                  height_reg, height_next;
    logic [conv3_pkg::CFG_DATA_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [conv3_pkg::IWIDTH_W-1:0]   cfg_w;
    logic                             cfg_we, size_write;

    // frame position
    logic [CW-1:0]   col_reg, col_next;
    conv3_pkg::row_t row_reg, row_next;
    logic            draining_reg, draining_next;

    // accept-side decode
    logic          accept, pix_go, drain_step, drain_final, step;
    logic          r_ge1, r_ge2, top_lo, emit_pre, emit_post, emits;
    logic [AW-1:0] at_x;

    // line stores
    conv3_pkg::pix_t upper_mem [MAX_WIDTH];
    conv3_pkg::pix_t lower_mem [MAX_WIDTH];
    conv3_pkg::pix_t rd_up_reg, rd_lo_reg;

    // stage 1: window update and line store write
    logic            s1_valid_reg, s1_drain_reg, s1_final_reg, s1_top_lo_reg;
    logic            s1_pre_reg, s1_post_reg, s1_ledge_reg, s1_fwd_reg;
    logic [AW-1:0]   s1_x_reg;
    conv3_pkg::pix_t s1_pix_reg, fwd_up_reg, fwd_lo_reg, up_eff, lo_eff;
    conv3_pkg::col_t new_col;
    logic            shift_en;
    logic [1:0]      lsel, csel, rsel;

    // stages 2..4: products, column sums, total
    conv3_pkg::ecoef_col_t s2_coef_reg [conv3_pkg::TAPS];
    conv3_pkg::ecoef_col_t coef_next   [conv3_pkg::TAPS];
    logic                  s2_valid_reg, s2_done_reg;
    logic                  s3_valid_reg, s3_done_reg;
    logic                  s4_valid_reg, s4_done_reg;
    conv3_pkg::col_t       tap_col [conv3_pkg::TAPS];
    conv3_pkg::csum_t      tap_sum [conv3_pkg::TAPS];
    conv3_pkg::sum_t       total;
    conv3_pkg::oq_word_t   push_word, head_word;

    // output credit
    logic [CRW-1:0] credit_reg, credit_next;
    logic           pop;

    // ------------------------------------------------------------------
    // configuration port
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;
    assign cfg_w      = cfg_data[conv3_pkg::IWIDTH_W-1:0];
    assign size_write = cfg_we && (cfg_index == conv3_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == conv3_pkg::REG_IMAGE_HEIGHT);

    always_comb begin
        if (cfg_w == '0) begin
            width_next = CW'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            width_next = CW'(MAX_WIDTH);
        end else begin
            width_next = CW'(cfg_w);
        end
        if (cfg_data[conv3_pkg::ROW_W-1:0] == '0) begin
            height_next = conv3_pkg::row_t'(1);
        end else begin
            height_next = cfg_data[conv3_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= CW'(WIDTH_RST);
            height_reg   <= conv3_pkg::row_t'(1024);
            coef_top_reg <= '0;
            coef_mid_reg <= '0;
            coef_bot_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                conv3_pkg::REG_IMAGE_WIDTH:  width_reg    <= width_next;
                conv3_pkg::REG_IMAGE_HEIGHT: height_reg   <= height_next;
                conv3_pkg::REG_COEF_TOP:     coef_top_reg <= cfg_data;
                conv3_pkg::REG_COEF_MID:     coef_mid_reg <= cfg_data;
                conv3_pkg::REG_COEF_BOTTOM:  coef_bot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // accept side: classify the word and advance the frame position
    assign s_tready = (credit_reg < CRW'(conv3_pkg::OQ_DEPTH));
    assign accept   = s_tvalid && s_tready;
    assign at_x     = col_reg[AW-1:0];

    always_comb begin
        pix_go      = !draining_reg && !s_tuser[0];
        drain_step  = draining_reg && (col_reg != width_reg);
        drain_final = draining_reg && (col_reg == width_reg);
        step        = pix_go || drain_step;
        // drain steps act as the row below the last one
        r_ge1  = draining_reg || (row_reg != '0);
        r_ge2  = draining_reg ? (height_reg > conv3_pkg::row_t'(1))
                              : (row_reg > conv3_pkg::row_t'(1));
        top_lo = draining_reg ? (height_reg == conv3_pkg::row_t'(1))
                              : (row_reg == conv3_pkg::row_t'(1));
        emit_pre  = step && (col_reg == '0) && r_ge2;
        emit_post = step && (col_reg != '0) && r_ge1;
        emits     = emit_pre || emit_post || drain_final;

        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (size_write) begin
            col_next      = '0;
            row_next      = '0;
            draining_next = 1'b0;
        end else if (accept) begin
            if (drain_final) begin
                col_next      = '0;
                row_next      = '0;
                draining_next = 1'b0;
            end else if (drain_step) begin
                col_next = col_reg + CW'(1);
            end else if (pix_go) begin
                if (col_reg == width_reg - CW'(1)) begin
                    col_next = '0;
                    if (row_reg == height_reg - conv3_pkg::row_t'(1)) begin
                        row_next      = '0;
                        draining_next = 1'b1;
                    end else begin
                        row_next = row_reg + conv3_pkg::row_t'(1);
                    end
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept && (step || drain_final);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg      <= at_x;
            s1_pix_reg    <= s_tdata;
            s1_drain_reg  <= draining_reg;
            s1_final_reg  <= drain_final;
            s1_top_lo_reg <= top_lo;
            s1_pre_reg    <= emit_pre;
            s1_post_reg   <= emit_post;
            s1_ledge_reg  <= (col_reg == CW'(1));
            // the store write of the word ahead lands on this same edge
            s1_fwd_reg    <= shift_en && (s1_x_reg == at_x);
            fwd_up_reg    <= lo_eff;
            fwd_lo_reg    <= new_col.bot;
        end
    end

    // line stores: read at accept, written from stage 1
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            upper_mem[s1_x_reg] <= lo_eff;
            lower_mem[s1_x_reg] <= new_col.bot;
        end
        if (accept) begin
            rd_up_reg <= upper_mem[at_x];
            rd_lo_reg <= lower_mem[at_x];
        end
    end

    always_comb begin
        up_eff      = s1_fwd_reg ? fwd_up_reg : rd_up_reg;
        lo_eff      = s1_fwd_reg ? fwd_lo_reg : rd_lo_reg;
        new_col.top = s1_top_lo_reg ? lo_eff : up_eff;
        new_col.mid = lo_eff;
        new_col.bot = s1_drain_reg ? lo_eff : s1_pix_reg;
        shift_en    = s1_valid_reg && !s1_final_reg;

        // column feeding each coefficient column, as seen after this shift
        if (s1_final_reg) begin
            lsel = (width_reg > CW'(1)) ? 2'd1 : 2'd2;
            csel = 2'd2;
            rsel = 2'd2;
        end else if (s1_pre_reg) begin
            lsel = (width_reg > CW'(1)) ? 2'd0 : 2'd1;
            csel = 2'd1;
            rsel = 2'd1;
        end else begin
            lsel = s1_ledge_reg ? 2'd1 : 2'd0;
            csel = 2'd1;
            rsel = 2'd2;
        end

        for (int k = 0; k < conv3_pkg::TAPS; k++) begin
            coef_next[k].top = merge_coef(coef_top_reg, lsel, csel, rsel, 2'(k));
            coef_next[k].mid = merge_coef(coef_mid_reg, lsel, csel, rsel, 2'(k));
            coef_next[k].bot = merge_coef(coef_bot_reg, lsel, csel, rsel, 2'(k));
        end
    end

    // ------------------------------------------------------------------
    // stages 2..4 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg && (s1_pre_reg || s1_post_reg || s1_final_reg);
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_done_reg <= s1_final_reg;
        s3_done_reg <= s2_done_reg;
        s4_done_reg <= s3_done_reg;
        for (int k = 0; k < conv3_pkg::TAPS; k++) begin
            s2_coef_reg[k] <= coef_next[k];
        end
    end

    // window: a chain of column cells, the newest column enters at the right
    genvar j;
    generate
        for (j = 0; j < conv3_pkg::TAPS; j++) begin : g_tap
            conv3_pkg::col_t feed;
            if (j == conv3_pkg::TAPS - 1) begin : g_head
                assign feed = new_col;
            end else begin : g_link
                assign feed = tap_col[j + 1];
            end
            conv3_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .col_in   (feed),
                .coef     (s2_coef_reg[j]),
                .col_out  (tap_col[j]),
                .sum_out  (tap_sum[j])
            );
        end
    endgenerate

    always_comb begin
        total = '0;
        for (int k = 0; k < conv3_pkg::TAPS; k++) begin
            total = total + conv3_pkg::sum_t'(tap_sum[k]);
        end
        push_word.done  = s4_done_reg;
        push_word.value = total[conv3_pkg::OUT_W-1:0];
    end

    // ------------------------------------------------------------------
    // result queue and credit
    conv3_oq u_oq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s4_valid_reg),
        .push_word  (push_word),
        .word_valid (m_tvalid),
        .pop        (pop),
        .head_word  (head_word)
    );

    assign pop     = m_tvalid && m_tready;
    assign m_tdata = {{(conv3_pkg::OUT_BUS_W - conv3_pkg::OUT_W){1'b0}}, head_word.value};
    assign m_tlast = head_word.done;

    always_comb begin
        credit_next = credit_reg;
        case ({accept && emits, pop})
            2'b10:   credit_next = credit_reg + CRW'(1);
            2'b01:   credit_next = credit_reg - CRW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    // ------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CRW'(conv3_pkg::OQ_DEPTH))
        else $error("result credit above queue depth");

    a_one_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $onehot0({s1_pre_reg, s1_post_reg, s1_final_reg}))
        else $error("word claims more than one result");

    a_drain_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg |-> (row_reg == '0))
        else $error("row counter moved during flush");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        draining_reg ? (col_reg <= width_reg) : (col_reg < width_reg))
        else $error("column counter out of range");

endmodule

FILE: verif/conv3x3_replicate_border_tb.sv
// Self-checking stream testbench for the 3x3 replicate-border convolution block.
`timescale 1ns / 1ps

module conv3x3_replicate_border_tb;
    import conv3_pkg::*;

    localparam int MAX_W            = 1024;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 12;
    localparam int END_CYCLES       = 20;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int FIRST_UNUSED_REG = REG_COEF_BOTTOM + 1;
    localparam int LAST_REG_INDEX   = (1 << CFG_IDX_W) - 1;
    localparam int WIDTH_ALL_ONES   = (1 << IWIDTH_W) - 1;
    localparam int HEIGHT_ALL_ONES  = (1 << ROW_W) - 1;
    localparam int MAX_REPORTS      = 40;

    localparam logic signed [PIX_W-1:0]  PIX_LOW      = {1'b1, {(PIX_W-1){1'b0}}};
    localparam logic signed [PIX_W-1:0]  PIX_HIGH     = {1'b0, {(PIX_W-1){1'b1}}};
    localparam logic [COEF_W-1:0]        COEF_LOW     = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]        COEF_HIGH    = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [CFG_DATA_W-1:0]    COEF_ALL_MIN = {TAPS{COEF_LOW}};
    localparam logic [CFG_DATA_W-1:0]    COEF_ALL_MAX = {TAPS{COEF_HIGH}};

    typedef enum int { FILL_RANDOM, FILL_MIN, FILL_MAX, FILL_MIXED } fill_t;

    typedef struct {
        logic signed [OUT_W-1:0] sum;
        logic                    frame_done;
    } conv_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_BUS_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: registers, line stores, window and raster position
    logic [IWIDTH_W-1:0]     width_reg;
    logic [ROW_W-1:0]        height_reg;
    logic [CFG_DATA_W-1:0]   coef_rows [TAPS];
    logic signed [PIX_W-1:0] line_up [MAX_W];
    logic signed [PIX_W-1:0] line_lo [MAX_W];
    logic signed [PIX_W-1:0] win [TAPS][TAPS];   // [column][top, mid, bottom]
    int                      row_pos;
    int                      col_pos;
    int                      drains_left;

    conv_out_t expected_sums[$];
    conv_out_t want;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;
    int  error_count  = 0;
    int  words_used   = 0;
    int  results_seen = 0;
    int  frames_done  = 0;
    int  reg_writes   = 0;

    conv3x3_replicate_border #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic longint window_sum(int left, int centre, int right);
        longint                   acc;
        logic signed [COEF_W-1:0] k [TAPS];
        acc = 0;
        for (int t = 0; t < TAPS; t++) begin
            for (int j = 0; j < TAPS; j++) k[j] = coef_rows[t][COEF_W*j +: COEF_W];
            acc += longint'(k[0]) * longint'(win[left][t])
                 + longint'(k[1]) * longint'(win[centre][t])
                 + longint'(k[2]) * longint'(win[right][t]);
        end
        return acc;
    endfunction

    function automatic void queue_result(longint sum, logic done);
        conv_out_t r;
        r.sum        = sum;
        r.frame_done = done;
        expected_sums.push_back(r);
    endfunction

    // Push one column of row r at column x; may close the row two above at its
    // right edge, and may emit the pixel one row up and one column left.
    function automatic void shift_column(int x, logic signed [PIX_W-1:0] p, int r, int w);
        logic signed [PIX_W-1:0] up;
        logic signed [PIX_W-1:0] lo;
        up = line_up[x];
        lo = line_lo[x];
        if (x == 0 && r >= 2) queue_result(window_sum(w >= 2 ? 1 : 2, 2, 2), 1'b0);
        for (int c = 0; c < TAPS - 1; c++)
            for (int t = 0; t < TAPS; t++) win[c][t] = win[c + 1][t];
        // replicate the top border on the second row
        win[2][0] = (r == 1) ? lo : up;
        win[2][1] = lo;
        win[2][2] = p;
        line_up[x] = lo;
        line_lo[x] = p;
        if (x >= 1 && r >= 1) queue_result(window_sum(x == 1 ? 1 : 0, 1, 2), 1'b0);
    endfunction

    function automatic void convolve_word(logic drain, logic signed [PIX_W-1:0] pix);
        int w;
        int h;
        w = eff_width();
        h = eff_height();
        if (drains_left > 0) begin
            if (col_pos < w) begin
                shift_column(col_pos, line_lo[col_pos], h, w);
                col_pos++;
                drains_left--;
            end else begin
                queue_result(window_sum(w >= 2 ? 1 : 2, 2, 2), 1'b1);
                drains_left = 0;
                col_pos     = 0;
                row_pos     = 0;
            end
        end else if (!drain) begin
            shift_column(col_pos, pix, row_pos, w);
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos     = 0;
                    drains_left = w + 1;
                end
            end
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_IMAGE_WIDTH:  width_reg    = data[IWIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg   = data[ROW_W-1:0];
            REG_COEF_TOP:     coef_rows[0] = data;
            REG_COEF_MID:     coef_rows[1] = data;
            REG_COEF_BOTTOM:  coef_rows[2] = data;
            default: ;
        endcase
        // a size write abandons the frame
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
            row_pos     = 0;
            col_pos     = 0;
            drains_left = 0;
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef_row();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_DATA_W-1:0];
    endfunction

    function automatic logic signed [PIX_W-1:0] pick_pixel(fill_t fill);
        logic signed [PIX_W-1:0] v;
        v = $urandom;
        case (fill)
            FILL_MIN:   v = PIX_LOW;
            FILL_MAX:   v = PIX_HIGH;
            FILL_MIXED: if ($urandom_range(3) == 0) v = $urandom_range(1) ? PIX_LOW : PIX_HIGH;
            default: ;
        endcase
        return v;
    endfunction

    task automatic flag_error(input string what);
        if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic send_word(input logic drain, input logic signed [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= drain;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (drains_left > 0 || !drain) words_used++;
        convolve_word(drain, pix);
    endtask

    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
    endtask

    // Empty the pipeline, including words that produce no result
    task automatic settle;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input int w, input int h, input logic [CFG_DATA_W-1:0] top,
                             input logic [CFG_DATA_W-1:0] mid,
                             input logic [CFG_DATA_W-1:0] bot);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COEF_TOP, top);
        write_reg(REG_COEF_MID, mid);
        write_reg(REG_COEF_BOTTOM, bot);
    endtask

    // Flush words carry random content; pixel words here act as drain
    task automatic drain_frame;
        while (drains_left > 0) send_word($urandom_range(1), pick_pixel(FILL_RANDOM));
    endtask

    task automatic run_frame(input fill_t fill, input int stop_after, input int noise_pct);
        int total;
        total = eff_width() * eff_height();
        for (int i = 0; i < total; i++) begin
            if (stop_after >= 0 && i == stop_after) begin
                settle();
                return;
            end
            // stray drain words while receiving are dropped
            if ($urandom_range(99) < noise_pct) send_word(1'b1, pick_pixel(FILL_RANDOM));
            send_word(1'b0, pick_pixel(fill));
        end
        drain_frame();
        frames_done++;
    endtask

    task automatic test_extremes;
        set_frame(2, 2, COEF_ALL_MIN, COEF_ALL_MIN, COEF_ALL_MIN);
        run_frame(FILL_MIN, -1, 0);
        set_frame(1, 1, COEF_ALL_MIN, COEF_ALL_MIN, COEF_ALL_MIN);
        run_frame(FILL_MAX, -1, 50);
    endtask

    task automatic test_special_cases;
        // zero sizes act as one; first flush word of a single-row frame is silent
        set_frame(0, 0, rand_coef_row(), rand_coef_row(), rand_coef_row());
        run_frame(FILL_MIXED, -1, 0);
        set_frame(1, 3, rand_coef_row(), rand_coef_row(), rand_coef_row());
        for (int i = FIRST_UNUSED_REG; i <= LAST_REG_INDEX; i++) write_reg(i, rand_coef_row());
        run_frame(FILL_RANDOM, -1, 0);
        set_frame(4, HEIGHT_ALL_ONES, rand_coef_row(), rand_coef_row(), rand_coef_row());
        run_frame(FILL_RANDOM, 5, 0);
    endtask

    task automatic test_large_frames;
        set_frame(WIDTH_ALL_ONES, 1, rand_coef_row(), rand_coef_row(), rand_coef_row());
        run_frame(FILL_RANDOM, -1, 0);
        set_frame(MAX_W, 3, rand_coef_row(), rand_coef_row(), rand_coef_row());
        run_frame(FILL_MIXED, -1, 0);
    endtask

    task automatic test_backpressure;
        int total;
        set_frame(8, 6, rand_coef_row(), rand_coef_row(), rand_coef_row());
        total = eff_width() * eff_height();
        for (int i = 0; i < total; i++) begin
            // long output stall from the third row on, then a full pause
            if (i == 2 * eff_width()) hold_request = 1'b1;
            if (i == total - 2 * eff_width()) wait_results_drained();
            send_word(1'b0, pick_pixel(FILL_RANDOM));
        end
        drain_frame();
        frames_done++;
    endtask

    task automatic test_random(input int word_budget);
        int                    goal;
        int                    w;
        int                    h;
        int                    stop;
        logic [CFG_DATA_W-1:0] k [TAPS];
        goal = words_used + word_budget;
        while (words_used < goal) begin
            w = ($urandom_range(7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            for (int t = 0; t < TAPS; t++) begin
                if ($urandom_range(7) == 0) k[t] = $urandom_range(1) ? COEF_ALL_MIN : COEF_ALL_MAX;
                else k[t] = rand_coef_row();
            end
            set_frame(w, h, k[0], k[1], k[2]);
            // some frames break off partway; the next size write restarts
            stop = -1;
            if ($urandom_range(7) == 0) stop = $urandom_range(0, eff_width() * eff_height() - 1);
            run_frame(FILL_MIXED, stop, 4);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_request = 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                flag_error($sformatf("result %0d with nothing expected",
                                     $signed(m_tdata[OUT_W-1:0])));
            end else begin
                want = expected_sums.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.sum)
                    flag_error($sformatf("sum %0d, expected %0d",
                                         $signed(m_tdata[OUT_W-1:0]), want.sum));
                if (m_tlast !== want.frame_done)
                    flag_error($sformatf("frame end flag %b, expected %b",
                                         m_tlast, want.frame_done));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        width_reg   = MAX_W;
        height_reg  = MAX_W;
        row_pos     = 0;
        col_pos     = 0;
        drains_left = 0;
        for (int t = 0; t < TAPS; t++) begin
            coef_rows[t] = '0;
            for (int c = 0; c < TAPS; c++) win[c][t] = '0;
        end
        for (int x = 0; x < MAX_W; x++) begin
            line_up[x] = '0;
            line_lo[x] = '0;
        end
        send_idle_pct = 26;
        recv_idle_pct = 66;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_special_cases();
        test_random(280);

        send_idle_pct = 66;
        recv_idle_pct = 26;
        test_large_frames();
        test_random(280);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(290);

        wait_results_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (expected_sums.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_sums.size()));
        $display("Covered %0d frames, %0d stream words, %0d results, %0d register writes",
                 frames_done, words_used, results_seen, reg_writes);
        $display("Sizes 1x1 to 1024 wide, extreme sums, stray drains, abandoned frames, stalls");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
